/* hw/rtl/wbps_pkg.sv */
// Shared types and constants for the wildcard byte pattern scanner.
package wbps_pkg;

  localparam int unsigned REG_PATTERN_BYTES   = 32;
  localparam int unsigned MAX_PATTERN_DEFAULT = 32;
  localparam int unsigned OFFSET_BITS_DEFAULT = 32;
  localparam int unsigned ADDR_BITS           = 64;
  localparam int unsigned CFG_INDEX_BITS      = 3;
  localparam int unsigned LEN_BITS            = 6;
  localparam int unsigned CARE_BITS           = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PATTERN_A  = 3'd0,
    CFG_PATTERN_B  = 3'd1,
    CFG_PATTERN_C  = 3'd2,
    CFG_PATTERN_D  = 3'd3,
    CFG_CARE_MASK  = 3'd4,
    CFG_PATTERN_LEN = 3'd5,
    CFG_BASE_ADDR  = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SCAN_NONE = 2'd0,
    SCAN_ONE  = 2'd1,
    SCAN_MANY = 2'd2
  } scan_status_t;

  // Input stage control handed from the window to the tally.
  typedef struct packed {
    logic valid;
    logic last;
  } item_ctl_t;

endpackage

/* hw/rtl/wbps_cfg.sv */
// Configuration register file: pattern bytes, care mask, length, base address.
module wbps_cfg (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        wr_en,
  input  logic [wbps_pkg::CFG_INDEX_BITS-1:0]         wr_index,
  input  logic [wbps_pkg::ADDR_BITS-1:0]              wr_data,
  output logic [8*wbps_pkg::REG_PATTERN_BYTES-1:0]    pattern,
  output logic [wbps_pkg::CARE_BITS-1:0]              care,
  output logic [wbps_pkg::LEN_BITS-1:0]               len,
  output logic [wbps_pkg::ADDR_BITS-1:0]              base
);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= '0;
      care    <= '0;
      len     <= '0;
      base    <= '0;
    end else if (wr_en) begin
      unique case (wbps_pkg::cfg_reg_t'(wr_index))
        wbps_pkg::CFG_PATTERN_A:   pattern[63:0]    <= wr_data;
        wbps_pkg::CFG_PATTERN_B:   pattern[127:64]  <= wr_data;
        wbps_pkg::CFG_PATTERN_C:   pattern[191:128] <= wr_data;
        wbps_pkg::CFG_PATTERN_D:   pattern[255:192] <= wr_data;
        wbps_pkg::CFG_CARE_MASK:   care <= wr_data[wbps_pkg::CARE_BITS-1:0];
        wbps_pkg::CFG_PATTERN_LEN: len  <= wr_data[wbps_pkg::LEN_BITS-1:0];
        wbps_pkg::CFG_BASE_ADDR:   base <= wr_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

/* hw/rtl/wbps_window.sv */
// Input stage: sliding byte window, image byte counter and input register.
module wbps_window #(
  parameter int unsigned CMP_BYTES   = wbps_pkg::REG_PATTERN_BYTES,
  parameter int unsigned OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       data_valid,
  output logic                       data_stall,
  input  logic [7:0]                 data_byte,
  input  logic                       last_byte,
  input  logic                       consume,
  output wbps_pkg::item_ctl_t        item,
  output logic [OFFSET_BITS-1:0]     item_seen,
  output logic [8*CMP_BYTES-1:0]     win
);

  logic [7:0]             window [CMP_BYTES];
  logic [OFFSET_BITS-1:0] seen;
  logic [OFFSET_BITS-1:0] seen_inc;
  logic                   accept;

  assign data_stall = item.valid && !consume;
  assign accept     = data_valid && !data_stall;
  // saturate at all ones
  assign seen_inc   = (&seen) ? seen : seen + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      item <= '0;
    end else begin
      if (accept) begin
        seen      <= last_byte ? '0 : seen_inc;
        item.valid <= 1'b1;
        item.last  <= last_byte;
      end else if (consume) begin
        item.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_seen <= seen_inc;
      for (int k = CMP_BYTES - 1; k > 0; k--) begin
        window[k] <= window[k-1];
      end
      window[0] <= data_byte;
    end
  end

  for (genvar k = 0; k < CMP_BYTES; k++) begin : g_pack
    assign win[8*k +: 8] = window[k];
  end

endmodule

/* hw/rtl/wbps_match.sv */
// Parallel wildcard compare of the pattern against the window.
module wbps_match #(
  parameter int unsigned CMP_BYTES   = wbps_pkg::REG_PATTERN_BYTES,
  parameter int unsigned OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic [8*CMP_BYTES-1:0]          win,
  input  logic [8*CMP_BYTES-1:0]          pattern,
  input  logic [CMP_BYTES-1:0]            care,
  input  logic [wbps_pkg::LEN_BITS-1:0]   len,
  input  logic [OFFSET_BITS-1:0]          seen,
  output logic                            hit
);

  localparam logic [wbps_pkg::LEN_BITS:0] CMP_W = (wbps_pkg::LEN_BITS + 1)'(CMP_BYTES);

  logic [8*CMP_BYTES-1:0]        rev;
  logic [8*CMP_BYTES-1:0]        aligned;
  logic [wbps_pkg::LEN_BITS:0]   shift;
  logic [CMP_BYTES-1:0]          miss;
  logic                          len_ok;
  logic                          seen_ok;

  // Oldest byte first, so pattern byte j lines up with window age len-1-j
  // after dropping CMP_BYTES-len bytes.
  for (genvar k = 0; k < CMP_BYTES; k++) begin : g_rev
    assign rev[8*k +: 8] = win[8*(CMP_BYTES-1-k) +: 8];
  end

  assign shift   = CMP_W - {1'b0, len};
  assign aligned = rev >> {shift, 3'b000};

  for (genvar j = 0; j < CMP_BYTES; j++) begin : g_cmp
    localparam logic [wbps_pkg::LEN_BITS-1:0] J = wbps_pkg::LEN_BITS'(j);
    assign miss[j] = (J < len) && care[j] && (aligned[8*j +: 8] != pattern[8*j +: 8]);
  end

  assign len_ok  = (len != '0) && ({1'b0, len} <= CMP_W);
  assign seen_ok = seen >= {{(OFFSET_BITS-wbps_pkg::LEN_BITS){1'b0}}, len};
  assign hit     = len_ok && seen_ok && !(|miss);

endmodule

/* hw/rtl/wbps_tally.sv */
// Match counting, first offset capture, result register and output register.
module wbps_tally #(
  parameter int unsigned OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  wbps_pkg::item_ctl_t               item,
  input  logic [OFFSET_BITS-1:0]            item_seen,
  input  logic                              hit,
  input  logic [wbps_pkg::LEN_BITS-1:0]     len,
  input  logic [wbps_pkg::ADDR_BITS-1:0]    base,
  output logic                              consume,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [1:0]                        scan_status,
  output logic [wbps_pkg::ADDR_BITS-1:0]    match_address
);

  wbps_pkg::scan_status_t count, count_next;
  logic [OFFSET_BITS-1:0] first, first_next;
  logic                   r_valid;
  wbps_pkg::scan_status_t r_status;
  logic [OFFSET_BITS-1:0] r_offset;
  logic                   o_free;
  logic                   r_move;
  logic                   r_free;

  assign o_free  = !result_valid || !result_stall;
  assign r_move  = r_valid && o_free;
  assign r_free  = !r_valid || r_move;
  assign consume = item.valid && (!item.last || r_free);

  always_comb begin
    count_next = count;
    first_next = first;
    if (hit) begin
      case (count)
        wbps_pkg::SCAN_NONE: begin
          count_next = wbps_pkg::SCAN_ONE;
          first_next = item_seen - {{(OFFSET_BITS-wbps_pkg::LEN_BITS){1'b0}}, len};
        end
        wbps_pkg::SCAN_ONE:  count_next = wbps_pkg::SCAN_MANY;
        default:             count_next = wbps_pkg::SCAN_MANY;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= wbps_pkg::SCAN_NONE;
      first        <= '0;
      r_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (consume) begin
        if (item.last) begin
          count <= wbps_pkg::SCAN_NONE;
          first <= '0;
        end else begin
          count <= count_next;
          first <= first_next;
        end
      end

      if (consume && item.last) begin
        r_valid <= 1'b1;
      end else if (r_move) begin
        r_valid <= 1'b0;
      end

      if (r_move) begin
        result_valid <= 1'b1;
      end else if (o_free) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && item.last) begin
      r_status <= count_next;
      r_offset <= first_next;
    end
    if (r_move) begin
      scan_status   <= r_status;
      match_address <= (r_status == wbps_pkg::SCAN_ONE)
                     ? base + {{(wbps_pkg::ADDR_BITS-OFFSET_BITS){1'b0}}, r_offset}
                     : '0;
    end
  end

endmodule

/* hw/rtl/wildcard_byte_pattern_scan.sv */
// Top level of the wildcard byte pattern scanner.
//
// Searches a byte image for a pattern of up to 32 bytes with wildcard
// positions and reports whether it occurs not at all, once, or more often.
// Config: write pattern bytes, care mask, length and base address through
//   cfg_valid/cfg_ready/cfg_index/cfg_data while no image is in flight.
//   cfg_ready is always high; unmapped indexes are dropped.
// Input: one image byte per word on data_byte, last_byte on the final byte.
//   A word is taken when data_valid is high and data_stall low.
// Output: one word per image (scan_status, match_address) on result_valid,
//   taken when result_stall is low. match_address is base plus the offset of
//   the match for a unique match, else zero.
// Throughput: one byte per cycle while data_stall is low; the window compare is fully parallel.
// Path: the last byte is held in the input register, compare and tally
//   write the result register, and the address add writes the output register.
// A stalled result holds the output register; a second result waits in the
//   result register behind it, and only a third image end stalls the input.
//   Bytes that end no image keep flowing while a result waits.
// Reset (rst, synchronous): clears configuration registers, counters and pipeline valids;
//   window contents are only read after being written for the current image.
module wildcard_byte_pattern_scan #(
  parameter int unsigned MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEFAULT,
  parameter int unsigned OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      data_valid,
  output logic                                      data_stall,
  input  logic [7:0]                                data_byte,
  input  logic                                      last_byte,
  output logic                                      result_valid,
  input  logic                                      result_stall,
  output logic [1:0]                                scan_status,
  output logic [wbps_pkg::ADDR_BITS-1:0]            match_address,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [wbps_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [wbps_pkg::ADDR_BITS-1:0]            cfg_data
);

  // Only window ages that a pattern can reach are kept.
  localparam int unsigned CMP_BYTES = (MAX_PATTERN < wbps_pkg::REG_PATTERN_BYTES)
                                    ? MAX_PATTERN : wbps_pkg::REG_PATTERN_BYTES;

  logic [8*wbps_pkg::REG_PATTERN_BYTES-1:0] pattern;
  logic [wbps_pkg::CARE_BITS-1:0]           care;
  logic [wbps_pkg::LEN_BITS-1:0]            len;
  logic [wbps_pkg::ADDR_BITS-1:0]           base;
  wbps_pkg::item_ctl_t                      item;
  logic [OFFSET_BITS-1:0]                   item_seen;
  logic [8*CMP_BYTES-1:0]                   win;
  logic                                     hit;
  logic                                     consume;

  assign cfg_ready = 1'b1;

  wbps_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .pattern  (pattern),
    .care     (care),
    .len      (len),
    .base     (base)
  );

  wbps_window #(
    .CMP_BYTES   (CMP_BYTES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .consume    (consume),
    .item       (item),
    .item_seen  (item_seen),
    .win        (win)
  );

  // Compare against the window as it stands after the held byte went in.
  wbps_match #(
    .CMP_BYTES   (CMP_BYTES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_match (
    .win     (win),
    .pattern (pattern[8*CMP_BYTES-1:0]),
    .care    (care[CMP_BYTES-1:0]),
    .len     (len),
    .seen    (item_seen),
    .hit     (hit)
  );

  wbps_tally #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_tally (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .item_seen     (item_seen),
    .hit           (hit),
    .len           (len),
    .base          (base),
    .consume       (consume),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .scan_status   (scan_status),
    .match_address (match_address)
  );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the wildcard byte pattern scanner.
module tb;

  // Allowance for the scan pipeline from the last byte to the result.
  localparam int unsigned SCAN_LATENCY = 2;
  // Cycles with no word moving on any channel before the run is declared hung.
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 160;
  localparam logic [wbps_pkg::CFG_INDEX_BITS-1:0] CFG_UNMAPPED = 3'd7;
  localparam logic [wbps_pkg::ADDR_BITS-1:0] ALL_ONES = '1;
  localparam longint unsigned OFFSET_MAX =
    (64'd1 << wbps_pkg::OFFSET_BITS_DEFAULT) - 64'd1;
  localparam bit MORE = 1'b0;
  localparam bit LAST = 1'b1;

  typedef enum int unsigned {
    PACE_FULL,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_t;

  typedef struct packed {
    wbps_pkg::scan_status_t         status;
    logic [wbps_pkg::ADDR_BITS-1:0] address;
  } scan_result_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                data_valid = 1'b0;
  logic                                data_stall;
  logic [7:0]                          data_byte = 8'h00;
  logic                                last_byte = 1'b0;
  logic                                result_valid;
  logic                                result_stall = 1'b0;
  logic [1:0]                          scan_status;
  logic [wbps_pkg::ADDR_BITS-1:0]      match_address;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [wbps_pkg::CFG_INDEX_BITS-1:0] cfg_index = wbps_pkg::CFG_PATTERN_A;
  logic [wbps_pkg::ADDR_BITS-1:0]      cfg_data = '0;

  wildcard_byte_pattern_scan dut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .scan_status  (scan_status),
    .match_address(match_address),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow copy of the pattern registers, as the block should hold them.
  logic [63:0]                    pat_regs [4] = '{default: '0};
  logic [wbps_pkg::CARE_BITS-1:0] care_bits = '0;
  logic [wbps_pkg::LEN_BITS-1:0]  pat_len = '0;
  logic [wbps_pkg::ADDR_BITS-1:0] base_addr = '0;

  // Shadow scan state: newest byte in slot 0.
  logic [7:0]      recent [wbps_pkg::MAX_PATTERN_DEFAULT] = '{default: '0};
  longint unsigned image_bytes = 0;
  int unsigned     hits = 0;
  longint unsigned first_hit = 0;

  scan_result_t expected_scans [$];
  int unsigned  mismatches = 0;

  // Pacing knobs, percent per cycle.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  function automatic logic [7:0] pattern_byte(input int unsigned j);
    return pat_regs[j / 8][8 * (j % 8) +: 8];
  endfunction

  // Does the pattern sit at the newest end of the window?
  // Pattern byte 0 lines up with the oldest byte of the candidate.
  function automatic bit window_hit();
    int unsigned n;
    n = pat_len;
    if (n == 0 || n > wbps_pkg::MAX_PATTERN_DEFAULT || n > wbps_pkg::REG_PATTERN_BYTES)
      return 1'b0;
    if (image_bytes < longint'(n)) return 1'b0;   // only bytes of this image count
    for (int unsigned j = 0; j < n; j++) begin
      if (care_bits[j] && recent[n - 1 - j] != pattern_byte(j)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the shadow scan by one accepted byte; queue the result on image end.
  function automatic void predict_byte(input logic [7:0] b, input logic last);
    scan_result_t r;
    for (int i = wbps_pkg::MAX_PATTERN_DEFAULT - 1; i > 0; i--) recent[i] = recent[i - 1];
    recent[0] = b;
    if (image_bytes < OFFSET_MAX) image_bytes++;
    if (window_hit()) begin
      if (hits == 0) first_hit = image_bytes - longint'(pat_len);
      if (hits < 2) hits++;
    end
    if (last) begin
      r.status  = wbps_pkg::scan_status_t'(hits[1:0]);
      r.address = (hits == 1) ? base_addr + first_hit : '0;
      expected_scans = {expected_scans, r};
      image_bytes = 0;
      hits        = 0;
      first_hit   = 0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Result side: check every word taken, then pick the stall for the next cycle.
  always @(posedge clk) begin : result_side
    scan_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_scans.size() == 0) begin
        report_mismatch("result word with none expected", match_address, '0);
      end else begin
        want = expected_scans.pop_front();
        if (scan_status !== want.status)
          report_mismatch("scan_status", 64'(scan_status), 64'(want.status));
        if (match_address !== want.address)
          report_mismatch("match_address", match_address, want.address);
      end
    end
    // A requested hold-off overrides the random stall until it runs out.
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: no word on any channel for too long means the block is hung.
  always @(posedge clk) begin
    if ((data_valid && !data_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic set_pace(input pace_t pace);
    case (pace)
      PACE_FULL:           begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      PACE_SENDER_IDLE:    begin send_idle_pct = 55; recv_stall_pct = 0;  end
      PACE_RECEIVER_STALL: begin send_idle_pct = 0;  recv_stall_pct = 55; end
      default:             begin send_idle_pct = 19; recv_stall_pct = 19; end
    endcase
  endtask

  // Offer one image byte, idling first at the current rate. Valid stays high
  // after the word is taken; the next call or drain decides what follows.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= last;
    do @(posedge clk); while (data_stall);
    predict_byte(b, last);
  endtask

  // One register write; valid is left high for back-to-back writes.
  task automatic write_word(input logic [wbps_pkg::CFG_INDEX_BITS-1:0] idx,
                            input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      wbps_pkg::CFG_PATTERN_A:   pat_regs[0] = value;
      wbps_pkg::CFG_PATTERN_B:   pat_regs[1] = value;
      wbps_pkg::CFG_PATTERN_C:   pat_regs[2] = value;
      wbps_pkg::CFG_PATTERN_D:   pat_regs[3] = value;
      wbps_pkg::CFG_CARE_MASK:   care_bits   = value[wbps_pkg::CARE_BITS-1:0];
      wbps_pkg::CFG_PATTERN_LEN: pat_len     = value[wbps_pkg::LEN_BITS-1:0];
      wbps_pkg::CFG_BASE_ADDR:   base_addr   = value;
      default: ;
    endcase
  endtask

  // Full register set. Junk goes into the unused high bits of the narrow
  // registers, and the unmapped index gets a write that must change nothing.
  task automatic configure(input logic [63:0] pa, input logic [63:0] pb,
                           input logic [63:0] pc, input logic [63:0] pd,
                           input logic [wbps_pkg::CARE_BITS-1:0] care,
                           input logic [wbps_pkg::LEN_BITS-1:0] len,
                           input logic [wbps_pkg::ADDR_BITS-1:0] base);
    write_word(wbps_pkg::CFG_PATTERN_A, pa);
    write_word(wbps_pkg::CFG_PATTERN_B, pb);
    write_word(wbps_pkg::CFG_PATTERN_C, pc);
    write_word(wbps_pkg::CFG_PATTERN_D, pd);
    write_word(wbps_pkg::CFG_CARE_MASK, {$urandom, care});
    write_word(wbps_pkg::CFG_PATTERN_LEN, {$urandom, 26'($urandom), len});
    write_word(wbps_pkg::CFG_BASE_ADDR, base);
    write_word(CFG_UNMAPPED, {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  // Wait for every expected result, then let the pipeline settle.
  task automatic drain();
    data_valid <= 1'b0;
    while (expected_scans.size() != 0) @(posedge clk);
    repeat (SCAN_LATENCY + 2) @(posedge clk);
  endtask

  // Random image of n bytes. Some bytes are drawn from the pattern itself,
  // and the pattern is planted up to 'plants' times so that single and
  // multiple matches turn up often; wildcard positions keep random bytes.
  task automatic random_image(input int unsigned n, input int unsigned plants);
    logic [7:0]  img [$];
    int unsigned pos;
    int unsigned plen;
    plen = pat_len;
    for (int unsigned i = 0; i < n; i++) begin
      if (plen >= 1 && plen <= wbps_pkg::REG_PATTERN_BYTES && $urandom_range(3) == 0)
        img = {img, pattern_byte($urandom_range(plen - 1))};
      else
        img = {img, 8'($urandom)};
    end
    for (int unsigned p = 0; p < plants; p++) begin
      if (plen >= 1 && plen <= wbps_pkg::REG_PATTERN_BYTES && plen <= n) begin
        pos = $urandom_range(n - plen);
        for (int unsigned j = 0; j < plen; j++)
          if (care_bits[j]) img[pos + j] = pattern_byte(j);
      end
    end
    foreach (img[i]) send_byte(img[i], i == img.size() - 1);
  endtask

  // Out of reset every register is zero: the empty pattern never matches.
  task automatic test_reset_defaults();
    set_pace(PACE_FULL);
    send_byte(8'hAB, MORE);
    send_byte(8'hCD, LAST);
    drain();
  endtask

  task automatic test_directed_cases();
    set_pace(PACE_FULL);
    // Pattern FF 00, both bytes cared for, base zero.
    configure(64'h00FF, 64'h0, 64'h0, 64'h0, 32'h3, 6'd2, 64'h0);
    send_byte(8'h00, MORE);          // unique match at offset 1
    send_byte(8'hFF, MORE);
    send_byte(8'h00, LAST);
    send_byte(8'hFF, MORE);          // unique match at address zero
    send_byte(8'h00, LAST);
    send_byte(8'hFF, MORE);          // two matches: ambiguous
    send_byte(8'h00, MORE);
    send_byte(8'hFF, MORE);
    send_byte(8'h00, LAST);
    send_byte(8'h5A, LAST);          // image shorter than the pattern
    drain();
    // Second byte wildcard; base at the top so base plus offset wraps to zero.
    configure(64'h00FF, 64'h0, 64'h0, 64'h0, 32'h1, 6'd2, ALL_ONES);
    send_byte(8'h7F, MORE);
    send_byte(8'hFF, MORE);
    send_byte(8'h5A, LAST);
    drain();
    // Overlapping occurrences of FF FF both count.
    configure(64'hFFFF, 64'h0, 64'h0, 64'h0, '1, 6'd2, 64'h1000);
    send_byte(8'hFF, MORE);
    send_byte(8'hFF, MORE);
    send_byte(8'hFF, LAST);
    drain();
    // Lengths above the window never match.
    configure(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, '1, 6'd33, 64'h20);
    send_byte(8'hFF, MORE);
    send_byte(8'hFF, LAST);
    drain();
    configure(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, '1, 6'd63, 64'h20);
    send_byte(8'hFF, LAST);
    drain();
    // One wildcard byte matches anything.
    configure(64'h0, 64'h0, 64'h0, 64'h0, 32'h0, 6'd1, 64'h8000_0000_0000_0000);
    send_byte(8'h00, LAST);
    drain();
  endtask

  // Random patterns and images under one pacing. The extreme phase uses the
  // widest pattern, every byte cared for, all-ones values and the top base.
  task automatic run_random_phase(input pace_t pace, input bit extreme,
                                  input int unsigned budget);
    logic [63:0]                    pats [4];
    logic [wbps_pkg::CARE_BITS-1:0] care;
    logic [wbps_pkg::LEN_BITS-1:0]  len;
    logic [wbps_pkg::ADDR_BITS-1:0] base;
    int unsigned                    sent;
    int unsigned                    n;
    drain();
    set_pace(pace);
    if (extreme) begin
      foreach (pats[i]) pats[i] = ALL_ONES;
      care = '1;
      len  = 6'd32;
      base = ALL_ONES;
    end else begin
      foreach (pats[i]) pats[i] = {$urandom, $urandom};
      care = ($urandom_range(2) == 0) ? '1 : $urandom;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: len = 6'($urandom_range(1, 4));
        6, 7:             len = 6'($urandom_range(5, 12));
        8:                len = 6'd32;
        default:          len = 6'($urandom_range(63));   // empty or overlong too
      endcase
      base = ($urandom_range(7) == 0) ? ALL_ONES : {$urandom, $urandom};
    end
    configure(pats[0], pats[1], pats[2], pats[3], care, len, base);
    sent = 0;
    while (sent < budget) begin
      if (len >= 24 && len <= 32)
        n = $urandom_range(len, len + 16);
      else
        n = $urandom_range(1, 24);
      random_image(n, $urandom_range(2));
      sent += n;
    end
  endtask

  task automatic test_random_scans();
    for (int p = 0; p < 8; p++)
      run_random_phase(pace_t'(p % 4), p == 1, 60);
  endtask

  // Result side holds off for a long stretch while short images keep coming,
  // so the result registers fill and the block must stall its input.
  task automatic test_backpressure();
    drain();
    set_pace(PACE_FULL);
    configure(64'h0, 64'h0, 64'h0, 64'h0, 32'h0, 6'd1, {$urandom, $urandom});
    hold_req = HOLD_CYCLES;
    for (int k = 0; k < 12; k++)
      for (int b = 0; b <= k % 2; b++)
        send_byte(8'($urandom), b == k % 2);
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed_cases();
    test_backpressure();
    test_random_scans();
    drain();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/wbps_pkg.sv
hw/rtl/wbps_cfg.sv
hw/rtl/wbps_window.sv
hw/rtl/wbps_match.sv
hw/rtl/wbps_tally.sv
hw/rtl/wildcard_byte_pattern_scan.sv
verif/tb.sv
